@@ rtl/ates_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ates_pkg
// Shared types, codes and helpers of the terminal screen engine.
// ----------------------------------------------------------------------------
package ates_pkg;

   // built maxima of the cell store
   localparam int MaxColsDefault = 128;
   localparam int MaxRowsDefault = 64;

   // default active area after reset
   localparam int ResetCols = 80;
   localparam int ResetRows = 24;

   // request kinds (tuser)
   localparam logic [2:0] FN_PRINT = 3'd0;
   localparam logic [2:0] FN_CTRL  = 3'd1;
   localparam logic [2:0] FN_CSI   = 3'd2;
   localparam logic [2:0] FN_ESC   = 3'd3;
   localparam logic [2:0] FN_SGR   = 3'd4;
   localparam logic [2:0] FN_PEEK  = 3'd5;

   // control bytes
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // CSI finals
   localparam logic [7:0] CSI_CUU = 8'h41; // A
   localparam logic [7:0] CSI_CUD = 8'h42; // B
   localparam logic [7:0] CSI_CUF = 8'h43; // C
   localparam logic [7:0] CSI_CUB = 8'h44; // D
   localparam logic [7:0] CSI_CUP = 8'h48; // H
   localparam logic [7:0] CSI_ED  = 8'h4A; // J
   localparam logic [7:0] CSI_EL  = 8'h4B; // K
   localparam logic [7:0] CSI_SU  = 8'h53; // S
   localparam logic [7:0] CSI_SD  = 8'h54; // T
   localparam logic [7:0] CSI_HVP = 8'h66; // f
   localparam logic [7:0] CSI_SGR = 8'h6D; // m

   // ESC finals
   localparam logic [7:0] ESC_IND = 8'h44; // D
   localparam logic [7:0] ESC_NEL = 8'h45; // E
   localparam logic [7:0] ESC_RI  = 8'h4D; // M
   localparam logic [7:0] ESC_RIS = 8'h63; // c

   // SGR values
   localparam logic [15:0] SGR_BOLD      = 16'd1;
   localparam logic [15:0] SGR_UNDER     = 16'd4;
   localparam logic [15:0] SGR_REVERSE   = 16'd7;
   localparam logic [15:0] SGR_NO_BOLD   = 16'd22;
   localparam logic [15:0] SGR_NO_UNDER  = 16'd24;
   localparam logic [15:0] SGR_NO_REV    = 16'd27;
   localparam logic [15:0] SGR_FG_LO     = 16'd30;
   localparam logic [15:0] SGR_FG_HI     = 16'd37;
   localparam logic [15:0] SGR_FG_DEF    = 16'd39;
   localparam logic [15:0] SGR_BG_LO     = 16'd40;
   localparam logic [15:0] SGR_BG_HI     = 16'd47;
   localparam logic [15:0] SGR_BG_DEF    = 16'd49;
   localparam logic [15:0] SGR_FGB_LO    = 16'd90;
   localparam logic [15:0] SGR_FGB_HI    = 16'd97;
   localparam logic [15:0] SGR_BGB_LO    = 16'd100;
   localparam logic [15:0] SGR_BGB_HI    = 16'd107;

   // current rendition: style bit0 bold, bit1 underline, bit2 reverse
   typedef struct packed {
      logic [2:0] style;
      logic [3:0] back;
      logic [3:0] fore;
   } pen_type;

   localparam pen_type PEN_RESET = '{style: 3'd0, back: 4'hF, fore: 4'hF};

   // cell word: {pen, codepoint}
   localparam logic [31:0] BLANK_CELL = {PEN_RESET, 21'h000020};

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic swp_read;
      logic swp_write;
      logic swp_copy;
      logic clr_write;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_go;
      logic src_ok;
      logic sweep_last;
      logic clr_last;
   } stat_type;

   function automatic pen_type sgr_apply(pen_type p, logic [15:0] v, logic [1:0] cnt);
      pen_type r;
      r = p;
      if (cnt == 2'd0 || v == 16'd0) r = PEN_RESET;
      else if (v == SGR_BOLD) r.style[0] = 1'b1;
      else if (v == SGR_UNDER) r.style[1] = 1'b1;
      else if (v == SGR_REVERSE) r.style[2] = 1'b1;
      else if (v == SGR_NO_BOLD) r.style[0] = 1'b0;
      else if (v == SGR_NO_UNDER) r.style[1] = 1'b0;
      else if (v == SGR_NO_REV) r.style[2] = 1'b0;
      else if (v == SGR_FG_DEF) r.fore = 4'hF;
      else if (v == SGR_BG_DEF) r.back = 4'hF;
      else if (v >= SGR_FG_LO && v <= SGR_FG_HI) r.fore = 4'(v - SGR_FG_LO);
      else if (v >= SGR_BG_LO && v <= SGR_BG_HI) r.back = 4'(v - SGR_BG_LO);
      else if (v >= SGR_FGB_LO && v <= SGR_FGB_HI) begin
         r.fore = 4'(v - SGR_FGB_LO);
         r.style[0] = 1'b1;
      end
      else if (v >= SGR_BGB_LO && v <= SGR_BGB_HI) r.back = 4'(v - SGR_BGB_LO);
      return r;
   endfunction

endpackage

@@ rtl/ates_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ates_ctrl
// Sequencer: clearing pass, request intake, row sweeps and response hand-off.
// ----------------------------------------------------------------------------
module ates_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ates_pkg::stat_type stat,
   output ates_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_COPY,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_DONE && slot_free);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.sweep_go ? ST_SWEEP : ST_DONE;
         end
         ST_SWEEP: begin
            if (stat.src_ok) begin
               cmd.swp_read = 1'b1;
               state_in     = ST_COPY;
            end else begin
               cmd.swp_write = 1'b1;
               if (stat.sweep_last) state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.swp_write = 1'b1;
            cmd.swp_copy  = 1'b1;
            state_in      = stat.sweep_last ? ST_DONE : ST_SWEEP;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_tvalid) begin
                  cmd.load_req = 1'b1;
                  state_in     = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a response is only produced when the output slot is free
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("response loaded over a pending one");

   // no request taken during the clearing pass or a sweep
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_SWEEP || state_ff == ST_COPY) |-> !req_tready)
      else $error("request taken while busy");

   // an executed request that starts no sweep goes on to the response step
   a_exec_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !stat.sweep_go) |=> state_ff == ST_DONE)
      else $error("execute did not reach completion");

endmodule

@@ rtl/ates_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ates_datapath
// Cell store, cursor, pen, active area, sweep address generator, response reg.
// ----------------------------------------------------------------------------
module ates_datapath #(
   parameter int MAX_COLS = ates_pkg::MaxColsDefault,
   parameter int MAX_ROWS = ates_pkg::MaxRowsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [79:0]        req_tdata,
   input  logic [2:0]         req_tuser,
   output logic [47:0]        rsp_tdata,
   input  logic               csr_valid,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data,
   input  ates_pkg::cmd_type  cmd,
   output ates_pkg::stat_type stat
);

   localparam int CIW = $clog2(MAX_COLS);
   localparam int RIW = $clog2(MAX_ROWS);
   localparam int CCW = $clog2(MAX_COLS + 1);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int AW  = CIW + RIW;
   localparam int RstCols = (ates_pkg::ResetCols > MAX_COLS) ? MAX_COLS : ates_pkg::ResetCols;
   localparam int RstRows = (ates_pkg::ResetRows > MAX_ROWS) ? MAX_ROWS : ates_pkg::ResetRows;

   // latched request
   logic [2:0]  func_ff;
   logic [20:0] char_ff;
   logic [7:0]  fb_ff;
   logic [15:0] a1_ff, a2_ff;
   logic [1:0]  cnt_ff;
   logic        skip_ff;
   logic [5:0]  pr_ff;
   logic [6:0]  pc_ff;

   // architectural state
   logic [CIW-1:0]    cur_col_ff, cur_col_in;
   logic [RIW-1:0]    cur_row_ff, cur_row_in;
   ates_pkg::pen_type pen_ff, pen_in;
   logic [CCW-1:0]    act_cols_ff;
   logic [RCW-1:0]    act_rows_ff;

   // sweep state
   logic [RIW-1:0] sy_ff, ey_ff, sy0, ey0;
   logic [CIW-1:0] sx_ff, ex_ff, sx0, ex0;
   logic           down_ff, copy_ff, dn0, cp0;
   logic [RCW-1:0] off_ff, off0;
   logic           go;

   // store
   logic [31:0]   mem [0:(1 << AW) - 1];
   logic [31:0]   rd_ff;
   logic          peek_oob_ff;
   logic [AW-1:0] clr_ff;
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [31:0]   wd;
   logic          re;

   logic [CIW-1:0] wm1;
   logic [RIW-1:0] hm1;
   assign wm1 = CIW'(act_cols_ff - 1'b1);
   assign hm1 = RIW'(act_rows_ff - 1'b1);

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_tuser;
         char_ff <= req_tdata[20:0];
         fb_ff   <= req_tdata[28:21];
         a1_ff   <= req_tdata[44:29];
         a2_ff   <= req_tdata[60:45];
         cnt_ff  <= req_tdata[62:61];
         skip_ff <= req_tdata[63];
         pr_ff   <= req_tdata[69:64];
         pc_ff   <= req_tdata[76:70];
      end
   end

   // action decode
   logic [15:0]    n, p, c, n_m1, c_m1;
   logic [16:0]    row_sum, col_sum;
   logic [CIW:0]   tab_col;
   logic [RCW-1:0] nh;
   logic           ld_scroll;
   logic [RIW-1:0] ld_row;
   logic [CIW-1:0] ex_col;
   logic [RIW-1:0] ex_row;
   ates_pkg::pen_type ex_pen;
   logic           prt_we;

   always_comb begin
      n         = (cnt_ff != 2'd0 && a1_ff != 16'd0) ? a1_ff : 16'd1;
      p         = (cnt_ff != 2'd0) ? a1_ff : 16'd0;
      c         = (cnt_ff[1] && a2_ff != 16'd0) ? a2_ff : 16'd1;
      n_m1      = n - 16'd1;
      c_m1      = c - 16'd1;
      row_sum   = 17'(cur_row_ff) + 17'(n);
      col_sum   = 17'(cur_col_ff) + 17'(n);
      tab_col   = ((CIW + 1)'(cur_col_ff) | (CIW + 1)'(7)) + (CIW + 1)'(1);
      nh        = (n > 16'(act_rows_ff)) ? act_rows_ff : RCW'(n);
      ld_scroll = (cur_row_ff == hm1);
      ld_row    = ld_scroll ? cur_row_ff : cur_row_ff + 1'b1;

      ex_col = cur_col_ff;
      ex_row = cur_row_ff;
      ex_pen = pen_ff;
      prt_we = 1'b0;
      go     = 1'b0;
      // default sweep: scroll up by one row
      sy0  = '0;
      sx0  = '0;
      ey0  = hm1;
      ex0  = wm1;
      dn0  = 1'b0;
      cp0  = 1'b1;
      off0 = RCW'(1);

      unique case (func_ff)
         ates_pkg::FN_PRINT: begin
            prt_we = 1'b1;
            if (cur_col_ff == wm1) begin
               ex_col = '0;
               ex_row = ld_row;
               go     = ld_scroll;
            end else begin
               ex_col = cur_col_ff + 1'b1;
            end
         end
         ates_pkg::FN_CTRL: begin
            priority case (fb_ff)
               ates_pkg::CH_LF: begin
                  ex_col = '0;
                  ex_row = ld_row;
                  go     = ld_scroll;
               end
               ates_pkg::CH_CR: ex_col = '0;
               ates_pkg::CH_BS: if (cur_col_ff != '0) ex_col = cur_col_ff - 1'b1;
               ates_pkg::CH_TAB: begin
                  if (tab_col >= (CIW + 1)'(act_cols_ff)) ex_col = wm1;
                  else ex_col = CIW'(tab_col);
               end
               default: ;
            endcase
         end
         ates_pkg::FN_CSI: begin
            if (!skip_ff) begin
               priority case (fb_ff)
                  ates_pkg::CSI_CUP, ates_pkg::CSI_HVP: begin
                     if (n_m1 < 16'(act_rows_ff)) ex_row = RIW'(n_m1);
                     if (c_m1 < 16'(act_cols_ff)) ex_col = CIW'(c_m1);
                  end
                  ates_pkg::CSI_CUU:
                     ex_row = (16'(cur_row_ff) < n) ? '0 : RIW'(16'(cur_row_ff) - n);
                  ates_pkg::CSI_CUD:
                     ex_row = (row_sum >= 17'(act_rows_ff)) ? hm1 : RIW'(row_sum);
                  ates_pkg::CSI_CUF:
                     ex_col = (col_sum >= 17'(act_cols_ff)) ? wm1 : CIW'(col_sum);
                  ates_pkg::CSI_CUB:
                     ex_col = (16'(cur_col_ff) < n) ? '0 : CIW'(16'(cur_col_ff) - n);
                  ates_pkg::CSI_ED: begin
                     cp0 = 1'b0;
                     if (p == 16'd0) begin
                        go  = 1'b1;
                        sy0 = cur_row_ff;
                        sx0 = cur_col_ff;
                     end else if (p == 16'd1) begin
                        go  = 1'b1;
                        ey0 = cur_row_ff;
                        ex0 = cur_col_ff;
                     end else if (p == 16'd2 || p == 16'd3) begin
                        go = 1'b1;
                     end
                  end
                  ates_pkg::CSI_EL: begin
                     cp0 = 1'b0;
                     sy0 = cur_row_ff;
                     ey0 = cur_row_ff;
                     if (p == 16'd0) begin
                        go  = 1'b1;
                        sx0 = cur_col_ff;
                     end else if (p == 16'd1) begin
                        go  = 1'b1;
                        ex0 = cur_col_ff;
                     end else if (p == 16'd2) begin
                        go = 1'b1;
                     end
                  end
                  ates_pkg::CSI_SU: begin
                     go   = 1'b1;
                     off0 = nh;
                  end
                  ates_pkg::CSI_SD: begin
                     go   = 1'b1;
                     off0 = nh;
                     dn0  = 1'b1;
                     sy0  = hm1;
                     ey0  = '0;
                  end
                  ates_pkg::CSI_SGR: ex_pen = ates_pkg::sgr_apply(pen_ff, a1_ff, cnt_ff);
                  default: ;
               endcase
            end
         end
         ates_pkg::FN_ESC: begin
            if (!skip_ff) begin
               priority case (fb_ff)
                  ates_pkg::ESC_IND: begin
                     ex_row = ld_row;
                     go     = ld_scroll;
                  end
                  ates_pkg::ESC_NEL: begin
                     ex_col = '0;
                     ex_row = ld_row;
                     go     = ld_scroll;
                  end
                  ates_pkg::ESC_RI: begin
                     if (cur_row_ff != '0) begin
                        ex_row = cur_row_ff - 1'b1;
                     end else begin
                        go  = 1'b1;
                        dn0 = 1'b1;
                        sy0 = hm1;
                        ey0 = '0;
                     end
                  end
                  ates_pkg::ESC_RIS: begin
                     ex_pen = ates_pkg::PEN_RESET;
                     ex_col = '0;
                     ex_row = '0;
                     go     = 1'b1;
                     cp0    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ates_pkg::FN_SGR: begin
            if (!skip_ff) ex_pen = ates_pkg::sgr_apply(pen_ff, a1_ff, cnt_ff);
         end
         default: ;
      endcase
   end

   // configuration values, clamped into 1..max
   logic [CCW-1:0] new_cols;
   logic [RCW-1:0] new_rows;
   logic           wr_cols, wr_rows;

   always_comb begin
      wr_cols = csr_valid && csr_index == 8'd0;
      wr_rows = csr_valid && csr_index == 8'd1;
      if (csr_data == 8'd0) new_cols = CCW'(1);
      else if (int'(csr_data) > MAX_COLS) new_cols = CCW'(MAX_COLS);
      else new_cols = CCW'(csr_data);
      if (csr_data[6:0] == 7'd0) new_rows = RCW'(1);
      else if (int'(csr_data[6:0]) > MAX_ROWS) new_rows = RCW'(MAX_ROWS);
      else new_rows = RCW'(csr_data[6:0]);
   end

   // cursor and pen next values, clamped on a configuration write
   always_comb begin
      cur_col_in = cmd.exec ? ex_col : cur_col_ff;
      cur_row_in = cmd.exec ? ex_row : cur_row_ff;
      pen_in     = cmd.exec ? ex_pen : pen_ff;
      if (wr_cols && CCW'(cur_col_in) >= new_cols) cur_col_in = CIW'(new_cols - 1'b1);
      if (wr_rows && RCW'(cur_row_in) >= new_rows) cur_row_in = RIW'(new_rows - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         pen_ff      <= ates_pkg::PEN_RESET;
         act_cols_ff <= CCW'(RstCols);
         act_rows_ff <= RCW'(RstRows);
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         pen_ff     <= pen_in;
         if (wr_cols) act_cols_ff <= new_cols;
         if (wr_rows) act_rows_ff <= new_rows;
      end
   end

   // sweep address generator
   logic [RCW:0]   src_sum;
   logic [RIW-1:0] src_row;
   logic [CIW-1:0] row_end;
   logic           x_done;

   always_comb begin
      src_sum = (RCW + 1)'(sy_ff) + (RCW + 1)'(off_ff);
      if (down_ff) begin
         stat.src_ok = copy_ff && (RCW'(sy_ff) >= off_ff);
         src_row     = RIW'(RCW'(sy_ff) - off_ff);
      end else begin
         stat.src_ok = copy_ff && (src_sum < (RCW + 1)'(act_rows_ff));
         src_row     = RIW'(src_sum);
      end
      row_end         = (sy_ff == ey_ff) ? ex_ff : wm1;
      x_done          = (sx_ff == row_end);
      stat.sweep_last = x_done && (sy_ff == ey_ff);
      stat.sweep_go   = go;
      stat.clr_last   = &clr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sy_ff   <= sy0;
         sx_ff   <= sx0;
         ey_ff   <= ey0;
         ex_ff   <= ex0;
         down_ff <= dn0;
         copy_ff <= cp0;
         off_ff  <= off0;
      end else if (cmd.swp_write) begin
         if (x_done) begin
            sy_ff <= down_ff ? sy_ff - 1'b1 : sy_ff + 1'b1;
            sx_ff <= '0;
         end else begin
            sx_ff <= sx_ff + 1'b1;
         end
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_write) clr_ff <= clr_ff + 1'b1;
   end

   // store port selection
   logic peek_oob;
   assign peek_oob = !(int'(pr_ff) < MAX_ROWS && int'(pc_ff) < MAX_COLS);

   always_comb begin
      we = 1'b0;
      wa = {sy_ff, sx_ff};
      wd = cmd.swp_copy ? rd_ff : ates_pkg::BLANK_CELL;
      if (cmd.clr_write) begin
         we = 1'b1;
         wa = clr_ff;
         wd = ates_pkg::BLANK_CELL;
      end else if (cmd.exec && prt_we) begin
         we = 1'b1;
         wa = {cur_row_ff, cur_col_ff};
         wd = {pen_ff, char_ff};
      end else if (cmd.swp_write) begin
         we = 1'b1;
      end
      re = cmd.swp_read || (cmd.exec && func_ff == ates_pkg::FN_PEEK);
      ra = cmd.swp_read ? {src_row, sx_ff} : {RIW'(pr_ff), CIW'(pc_ff)};
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (re) rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) peek_oob_ff <= peek_oob;
   end

   // response register
   logic [31:0] cell_out;
   logic [47:0] rsp_ff;

   always_comb begin
      if (func_ff != ates_pkg::FN_PEEK) cell_out = '0;
      else if (peek_oob_ff) cell_out = ates_pkg::BLANK_CELL;
      else cell_out = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= {3'd0, cell_out, 6'(cur_row_ff), 7'(cur_col_ff)};
   end

   assign rsp_tdata = rsp_ff;

   // cursor stays inside the active area
   a_col_in_area: assert property (@(posedge clock) disable iff (reset)
      CCW'(cur_col_ff) < act_cols_ff)
      else $error("cursor column outside active area");

   a_row_in_area: assert property (@(posedge clock) disable iff (reset)
      RCW'(cur_row_ff) < act_rows_ff)
      else $error("cursor row outside active area");

   // active area never empty nor wider than the store
   a_area_range: assert property (@(posedge clock) disable iff (reset)
      act_cols_ff != '0 && int'(act_cols_ff) <= MAX_COLS && act_rows_ff != '0)
      else $error("active area out of range");

endmodule

@@ rtl/ansi_terminal_screen_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_terminal_screen_engine
// Character-cell screen engine driven by pre-parsed terminal actions.
// ----------------------------------------------------------------------------
// Usage:
//  req_* stream takes one parsed action per request (print, control byte,
//  CSI final, ESC final, SGR value, cell read); rsp_* returns one response
//  per request with the cursor after the action and, for a read, the cell.
//  csr_* writes the active column count (index 0) or row count (index 1);
//  write it only while no request is in flight. csr_ready is always high.
// Steps:
//  Print, cursor moves, control bytes, SGR and cell reads pass through the
//  execute step and the response hand-off step. Erases add a sweep that
//  writes each blanked cell; scrolls (also a wrap or line feed at the bottom
//  row) add a sweep that blanks vacated cells and copies the others, each
//  copied cell being read into a register first and then written.
// Reset:
//  Synchronous, active high. Afterwards a clearing pass writes every one of
//  2^clog2(MAX_ROWS) x 2^clog2(MAX_COLS) cells (8192 at default size) to a
//  blank, one per cycle; req_tready stays low until it ends.
// Stalls:
//  A finished response waits in the output register while rsp_tready is
//  low; one further request is taken and executed meanwhile.
// ----------------------------------------------------------------------------
module ansi_terminal_screen_engine #(
   parameter int MAX_COLS = ates_pkg::MaxColsDefault,
   parameter int MAX_ROWS = ates_pkg::MaxRowsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[20:0] final_byte[28:21] first_arg[44:29] second_arg[60:45]
   // arg_count[62:61] skip_flag[63] peek_row[69:64] peek_col[76:70]
   input  logic [79:0] req_tdata,
   // func[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_col[6:0] cursor_row[12:7] cell_char[33:13] cell_fore[37:34]
   // cell_back[41:38] cell_style[44:42]
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   ates_pkg::cmd_type  cmd;
   ates_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ates_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ates_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
